// ----- hw/rtl/cdcs_pkg.sv -----
// shared constants and types of the directory catalog scanner
package cdcs_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ENTRY_BYTES = 32;
  localparam int NAME_CHARS  = 11;
  localparam int CHAR_W      = 7;
  localparam int NAME_W      = NAME_CHARS * CHAR_W;
  localparam int ENTRY_AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int POS_W       = $clog2(ENTRY_BYTES);
  localparam int SIZE_POS    = 15;

  localparam logic [CHAR_W-1:0] CHAR_LOW  = 7'h20;
  localparam logic [CHAR_W-1:0] CHAR_HIGH = 7'h5A;

  typedef enum logic [2:0] {
    CMD_START      = 3'd0,
    CMD_BYTE       = 3'd1,
    CMD_END_SECTOR = 3'd2,
    CMD_END_TRACK  = 3'd3,
    CMD_READ       = 3'd4
  } cmd_e;

  typedef struct packed {
    logic              added;
    logic [6:0]        count;
    logic              done;
    logic              drop;
    logic [CHAR_W-1:0] rchar;
  } res_t;

endpackage

// ----- hw/rtl/cdcs_ram.sv -----
// generic simple dual-port ram with registered read
module cdcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/cpm_directory_catalog_scanner.sv -----
// top level of the directory catalog scanner
//
// input channel: one word per command (start scan, directory byte, end of
// sector, end of track, read stored character), with in_valid_i/in_stall_o.
// output channel: exactly one result word per input word, with
// out_valid_o/out_stall_i; status fields show the state after the command.
// names live in a ram of MAX_ENTRIES rows, one row holds all 11 characters.
// status commands and bytes that do not end an entry give their result
// through the output register, and another word can be accepted at once
// unless that result waits in the hold register. a read goes through one
// ram read. the last byte of a valid entry walks the stored rows through the
// ram read port, one row a cycle, until the name matches or the rows run out.
// reset empties the catalog and clears the scan; the name ram is not
// cleared, rows at or above entry_count are never read.
// a stalled receiver holds the output register; one finished result can
// wait in a hold register, after which in_stall_o stays high until the
// output register drains.
module cpm_directory_catalog_scanner
  import cdcs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] command_i,
  input  logic [7:0] dir_byte_i,
  input  logic [5:0] entry_index_i,
  input  logic [3:0] char_index_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       entry_added_o,
  output logic [6:0] entry_count_o,
  output logic       scan_done_o,
  output logic       overflow_drop_o,
  output logic [6:0] read_char_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RDWAIT,
    ST_HOLD
  } state_e;

  state_e              state_q, state_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic                valid_q, valid_d;
  logic                closed_q, closed_d;
  logic [CHAR_W-1:0]   cur_q [NAME_CHARS];
  logic [CHAR_W-1:0]   cur_d [NAME_CHARS];
  logic [COUNT_W-1:0]  iss_q, iss_d;
  logic                cmpv_q, cmpv_d;
  logic [3:0]          rd_ci_q, rd_ci_d;
  res_t                hold_q, hold_d;
  logic                out_valid_q, out_valid_d;
  res_t                out_q, out_d;

  logic                ram_we;
  logic [ENTRY_AW-1:0] ram_waddr;
  logic [NAME_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [ENTRY_AW-1:0] ram_raddr;
  logic [NAME_W-1:0]   ram_rdata;

  logic [NAME_W-1:0]   cur_packed;
  logic                slot_free;
  logic                fin;
  res_t                res;

  // the name of the entry being received, packed like a ram row
  always_comb begin
    for (int k = 0; k < NAME_CHARS; k++) begin
      cur_packed[k*CHAR_W +: CHAR_W] = cur_q[k];
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign slot_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    logic              ok;
    logic [CHAR_W-1:0] c;
    logic              match;
    logic              issue;

    state_d     = state_q;
    count_d     = count_q;
    pos_d       = pos_q;
    valid_d     = valid_q;
    closed_d    = closed_q;
    cur_d       = cur_q;
    iss_d       = iss_q;
    cmpv_d      = 1'b0;
    rd_ci_d     = rd_ci_q;
    hold_d      = hold_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    ram_we      = 1'b0;
    ram_waddr   = count_q[ENTRY_AW-1:0];
    ram_wdata   = cur_packed;
    ram_re      = 1'b0;
    ram_raddr   = iss_q[ENTRY_AW-1:0];

    fin         = 1'b0;
    res         = '0;
    ok          = valid_q;
    c           = dir_byte_i[CHAR_W-1:0];
    match       = 1'b0;
    issue       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (command_i)
            CMD_START: begin
              count_d  = '0;
              closed_d = 1'b0;
              pos_d    = '0;
              valid_d  = 1'b1;
              fin      = 1'b1;
            end
            CMD_BYTE: begin
              if (!closed_q) begin
                if (pos_q == '0) begin
                  if (dir_byte_i != 8'd0) ok = 1'b0;
                end else if (32'(pos_q) <= NAME_CHARS) begin
                  for (int k = 0; k < NAME_CHARS; k++) begin
                    if (32'(pos_q) == k + 1) cur_d[k] = c;
                  end
                  if (c < CHAR_LOW || c > CHAR_HIGH) ok = 1'b0;
                end else if (32'(pos_q) == SIZE_POS) begin
                  if (dir_byte_i == 8'd0) ok = 1'b0;
                end
                if (32'(pos_q) == ENTRY_BYTES - 1) begin
                  if (ok) begin
                    // entry complete and valid: look for the name in the ram
                    state_d = ST_SEARCH;
                    iss_d   = '0;
                  end else begin
                    pos_d   = '0;
                    valid_d = 1'b1;
                    fin     = 1'b1;
                  end
                end else begin
                  pos_d   = pos_q + POS_W'(1);
                  valid_d = ok;
                  fin     = 1'b1;
                end
              end else begin
                fin = 1'b1;
              end
            end
            CMD_END_SECTOR: begin
              pos_d   = '0;
              valid_d = 1'b1;
              fin     = 1'b1;
            end
            CMD_END_TRACK: begin
              pos_d   = '0;
              valid_d = 1'b1;
              if (count_q != '0) closed_d = 1'b1;
              fin     = 1'b1;
            end
            CMD_READ: begin
              if (32'(entry_index_i) < 32'(count_q) &&
                  32'(char_index_i) < NAME_CHARS) begin
                ram_re    = 1'b1;
                ram_raddr = ENTRY_AW'(entry_index_i);
                rd_ci_d   = char_index_i;
                state_d   = ST_RDWAIT;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_SEARCH: begin
        // one row issued and one row compared per cycle
        match  = cmpv_q && (ram_rdata == cur_packed);
        issue  = (iss_q < count_q) && !match;
        ram_re = issue;
        cmpv_d = issue;
        if (issue) iss_d = iss_q + COUNT_W'(1);
        if (match || !issue) begin
          if (!match) begin
            if (count_q < COUNT_W'(MAX_ENTRIES)) begin
              ram_we    = 1'b1;
              count_d   = count_q + COUNT_W'(1);
              res.added = 1'b1;
            end else begin
              res.drop = 1'b1;
            end
          end
          pos_d   = '0;
          valid_d = 1'b1;
          fin     = 1'b1;
        end
      end
      ST_RDWAIT: begin
        for (int k = 0; k < NAME_CHARS; k++) begin
          if (32'(rd_ci_q) == k) res.rchar = ram_rdata[k*CHAR_W +: CHAR_W];
        end
        fin = 1'b1;
      end
      ST_HOLD: begin
        if (slot_free) begin
          out_d       = hold_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      res.count = 7'(count_d);
      res.done  = closed_d;
      if (slot_free) begin
        out_d       = res;
        out_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end else begin
        hold_d  = res;
        state_d = ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      valid_q     <= 1'b1;
      closed_q    <= 1'b0;
      cmpv_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      valid_q     <= valid_d;
      closed_q    <= closed_d;
      cmpv_q      <= cmpv_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    iss_q   <= iss_d;
    rd_ci_q <= rd_ci_d;
    hold_q  <= hold_d;
  end

  cdcs_ram #(
    .WIDTH (NAME_W),
    .DEPTH (MAX_ENTRIES),
    .AW    (ENTRY_AW)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign entry_added_o   = out_q.added;
  assign entry_count_o   = out_q.count;
  assign scan_done_o     = out_q.done;
  assign overflow_drop_o = out_q.drop;
  assign read_char_o     = out_q.rchar;

endmodule

// ----- tb/cpm_directory_catalog_scanner_tb.sv -----
// testbench of the directory catalog scanner: directed and random directory streams checked word by word
module cpm_directory_catalog_scanner_tb
  import cdcs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // command codes the block leaves unused, reported as plain status
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

  // the short scans stop growing at this many words, then the catalog gets filled
  localparam int SHORT_SCAN_WORDS = 300;
  // distinct names offered in the filling scan, a few past capacity
  localparam int FILL_TARGET      = MAX_ENTRIES + 4;
  // one long receiver hold once this many words went in
  localparam int HOLD_AFTER_WORDS = 400;
  localparam int HOLD_CYCLES      = 300;
  // worst entry end walks every stored row plus ram read
  localparam int TAIL_CYCLES      = MAX_ENTRIES + 40;
  localparam int SHOWN_LIMIT      = 50;

  typedef logic [NAME_CHARS-1:0][CHAR_W-1:0] name_t;

  // one input word as seen on the ports
  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data;
    logic [5:0] eidx;
    logic [3:0] cidx;
  } dir_word_t;

  typedef enum int {ENT_GOOD, ENT_BAD_USER, ENT_BAD_SIZE, ENT_BAD_CHAR, ENT_CUT} entry_kind_e;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_e;

  logic       clk_i           = 1'b0;
  logic       rst_ni          = 1'b0;
  logic       in_valid_i      = 1'b0;
  logic       in_stall_o;
  logic [2:0] command_i       = CMD_START;
  logic [7:0] dir_byte_i      = 8'h00;
  logic [5:0] entry_index_i   = 6'h00;
  logic [3:0] char_index_i    = 4'h0;
  logic       out_valid_o;
  logic       out_stall_i     = 1'b0;
  logic       entry_added_o;
  logic [6:0] entry_count_o;
  logic       scan_done_o;
  logic       overflow_drop_o;
  logic [6:0] read_char_o;

  cpm_directory_catalog_scanner dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .dir_byte_i      (dir_byte_i),
    .entry_index_i   (entry_index_i),
    .char_index_i    (char_index_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .entry_added_o   (entry_added_o),
    .entry_count_o   (entry_count_o),
    .scan_done_o     (scan_done_o),
    .overflow_drop_o (overflow_drop_o),
    .read_char_o     (read_char_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // words waiting to be offered, and status words the block still owes
  dir_word_t scan_words [$];
  res_t      status_due [$];

  // catalog model state
  name_t cat_names [MAX_ENTRIES];
  int    cat_count    = 0;
  int    entry_pos    = 0;
  name_t entry_name   = '0;
  logic  entry_ok     = 1'b1;
  logic  track_closed = 1'b0;

  // run statistics
  int accepted_words = 0;
  int names_added    = 0;
  int names_dropped  = 0;
  int scans_closed   = 0;
  int chars_read     = 0;
  int mismatch_count = 0;

  // generator bookkeeping: good names offered in the current scan
  name_t scan_names [$];
  int    gen_distinct = 0;

  // handshake bookkeeping
  logic        in_taken   = 1'b0;
  int          gap_left   = 0;
  int          burst_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  int          mode_left  = 0;
  int          hold_left  = 0;
  logic        hold_done  = 1'b0;
  int          phase      = 0;

  // ---------------------------------------------------------------------------
  // catalog model
  // ---------------------------------------------------------------------------

  function automatic void entry_restart();
    entry_pos  = 0;
    entry_ok   = 1'b1;
    entry_name = '0;
  endfunction

  // applies one accepted word and returns the status word it must produce
  function automatic res_t catalog_apply(input dir_word_t w);
    res_t             r;
    int               pos;
    logic             known;
    logic [CHAR_W-1:0] ch;
    r     = '0;
    known = 1'b0;
    ch    = w.data[CHAR_W-1:0];
    case (w.cmd)
      CMD_START: begin
        cat_count    = 0;
        track_closed = 1'b0;
        entry_restart();
      end
      CMD_BYTE: begin
        // nothing moves once the track closed
        if (!track_closed) begin
          pos = entry_pos;
          if (pos == 0) begin
            // user byte must be exactly zero, bit 7 included
            if (w.data != 8'h00) entry_ok = 1'b0;
          end else if (pos <= NAME_CHARS) begin
            entry_name[pos-1] = ch;
            if (ch < CHAR_LOW || ch > CHAR_HIGH) entry_ok = 1'b0;
          end else if (pos == SIZE_POS) begin
            // empty record count means a deleted or unused slot
            if (w.data == 8'h00) entry_ok = 1'b0;
          end
          if (pos == ENTRY_BYTES - 1) begin
            for (int e = 0; e < cat_count; e++) begin
              if (cat_names[e] == entry_name) known = 1'b1;
            end
            if (entry_ok && !known) begin
              if (cat_count < MAX_ENTRIES) begin
                cat_names[cat_count] = entry_name;
                cat_count++;
                r.added = 1'b1;
                names_added++;
              end else begin
                r.drop = 1'b1;
                names_dropped++;
              end
            end
            entry_restart();
          end else begin
            entry_pos = pos + 1;
          end
        end
      end
      CMD_END_SECTOR: entry_restart();
      CMD_END_TRACK: begin
        // partial entry dropped; closes only with something stored
        entry_restart();
        if (cat_count > 0) begin
          if (!track_closed) scans_closed++;
          track_closed = 1'b1;
        end
      end
      CMD_READ: begin
        if (w.eidx < cat_count && w.cidx < NAME_CHARS) begin
          r.rchar = cat_names[w.eidx][w.cidx];
          if (r.rchar != '0) chars_read++;
        end
      end
      default: ;
    endcase
    r.count = 7'(cat_count);
    r.done  = track_closed;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  task automatic push_word(input logic [2:0] cmd, input logic [7:0] data,
                           input logic [5:0] eidx, input logic [3:0] cidx);
    dir_word_t w;
    w.cmd  = cmd;
    w.data = data;
    w.eidx = eidx;
    w.cidx = cidx;
    scan_words.push_back(w);
  endtask

  // read mostly near the stored range, sometimes anywhere
  task automatic push_read();
    int hi;
    hi = (gen_distinct < MAX_ENTRIES) ? gen_distinct : MAX_ENTRIES - 1;
    push_word(CMD_READ, 8'($urandom),
              ($urandom_range(7, 0) == 0) ? 6'($urandom) : 6'($urandom_range(hi, 0)),
              ($urandom_range(7, 0) == 0) ? 4'($urandom)
                                          : 4'($urandom_range(NAME_CHARS - 1, 0)));
  endtask

  // directory byte, now and then followed by a read or a spare command
  task automatic push_byte(input logic [7:0] b);
    push_word(CMD_BYTE, b, 6'($urandom), 4'($urandom));
    if ($urandom_range(99, 0) < 3) begin
      push_read();
    end else if ($urandom_range(199, 0) == 0) begin
      push_word(3'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)), 8'($urandom),
                6'($urandom), 4'($urandom));
    end
  endtask

  function automatic name_t fresh_name();
    name_t nm;
    for (int i = 0; i < NAME_CHARS; i++) nm[i] = 7'($urandom_range(CHAR_HIGH, CHAR_LOW));
    return nm;
  endfunction

  // one 32-byte entry carrying nm, spoiled the way kind says
  task automatic push_entry(input entry_kind_e kind, input name_t nm);
    int                bad_pos;
    int                cut_len;
    logic [CHAR_W-1:0] ch;
    logic [7:0]        b;
    bad_pos = $urandom_range(NAME_CHARS, 1);
    cut_len = $urandom_range(ENTRY_BYTES - 1, 1);
    for (int p = 0; p < ENTRY_BYTES; p++) begin
      if (kind == ENT_CUT && p == cut_len) begin
        push_word(CMD_END_SECTOR, 8'($urandom), 6'($urandom), 4'($urandom));
        return;
      end
      if (p == 0) begin
        b = (kind == ENT_BAD_USER) ? 8'($urandom_range(255, 1)) : 8'h00;
      end else if (p <= NAME_CHARS) begin
        ch = nm[p-1];
        if (kind == ENT_BAD_CHAR && p == bad_pos) begin
          ch = ($urandom_range(1, 0) == 0) ? 7'($urandom_range(CHAR_LOW - 1, 0))
                                           : 7'($urandom_range(127, CHAR_HIGH + 1));
        end
        // bit 7 is an attribute flag and gets masked off
        b = {1'($urandom), ch};
      end else if (p == SIZE_POS) begin
        b = (kind == ENT_BAD_SIZE) ? 8'h00 : 8'($urandom_range(255, 1));
      end else begin
        b = 8'($urandom);
      end
      push_byte(b);
    end
  endtask

  // fresh name, repeat of an earlier one (maybe one char off), or a spoiled entry
  task automatic push_random_entry(input int pct_fresh, input int pct_dup);
    name_t nm;
    int    roll;
    roll = $urandom_range(99, 0);
    if (roll < pct_fresh || (roll < pct_fresh + pct_dup && scan_names.size() == 0)) begin
      nm = fresh_name();
      scan_names.push_back(nm);
      gen_distinct++;
      push_entry(ENT_GOOD, nm);
    end else if (roll < pct_fresh + pct_dup) begin
      nm = scan_names[$urandom_range(scan_names.size() - 1, 0)];
      if ($urandom_range(2, 0) == 0) begin
        nm[$urandom_range(NAME_CHARS - 1, 0)] = 7'($urandom_range(CHAR_HIGH, CHAR_LOW));
        scan_names.push_back(nm);
        gen_distinct++;
      end
      push_entry(ENT_GOOD, nm);
    end else begin
      push_entry(entry_kind_e'($urandom_range(ENT_CUT, ENT_BAD_USER)), fresh_name());
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers queued words in bursts, holds a word until it is taken
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin : drive
    dir_word_t w;
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (gap_left > 0 || scan_words.size() == 0) begin
        in_valid_i <= 1'b0;
        if (gap_left > 0) gap_left = gap_left - 1;
      end else begin
        w = scan_words.pop_front();
        in_valid_i    <= 1'b1;
        command_i     <= w.cmd;
        dir_byte_i    <= w.data;
        entry_index_i <= w.eidx;
        char_index_i  <= w.cidx;
        if (burst_left > 1) begin
          burst_left = burst_left - 1;
        end else begin
          // new burst; a third of them follow with no gap at all
          burst_left = $urandom_range(48, 1);
          gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver stall pattern, with one long hold to back the block up
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin : stall_pattern
    logic hold_now;
    if (!hold_done && accepted_words >= HOLD_AFTER_WORDS) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      hold_now  = 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(STALL_PERIODIC, STALL_NONE));
        mode_left  = $urandom_range(150, 10);
      end
      mode_left = mode_left - 1;
      phase     = phase + 1;
      case (stall_mode)
        STALL_NONE:  hold_now = 1'b0;
        STALL_LIGHT: hold_now = ($urandom_range(3, 0) == 0);
        STALL_HEAVY: hold_now = ($urandom_range(3, 0) != 0);
        default:     hold_now = (phase % 5) < 2;
      endcase
    end
    out_stall_i <= hold_now;
  end

  // ---------------------------------------------------------------------------
  // monitor: checks status words, predicts from accepted words
  // ---------------------------------------------------------------------------

  task automatic check_field(input string fname, input logic [6:0] want_v,
                             input logic [6:0] got_v);
    if (got_v !== want_v) begin
      mismatch_count++;
      if (mismatch_count <= SHOWN_LIMIT) begin
        $display("%0t: %s expected %0d, got %0d", $time, fname, want_v, got_v);
      end else if (mismatch_count == SHOWN_LIMIT + 1) begin
        $display("further mismatches not shown");
      end
    end
  endtask

  always @(posedge clk_i) begin : watch
    res_t got;
    res_t want;
    if (rst_ni) begin
      // status word leaving the block, against the oldest one owed
      if (out_valid_o && !out_stall_i) begin
        got = {entry_added_o, entry_count_o, scan_done_o, overflow_drop_o, read_char_o};
        if (status_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_LIMIT) begin
            $display("%0t: status word with none expected, expected nothing, got %h",
                     $time, got);
          end
        end else begin
          want = status_due.pop_front();
          check_field("entry_added", want.added, got.added);
          check_field("entry_count", want.count, got.count);
          check_field("scan_done", want.done, got.done);
          check_field("overflow_drop", want.drop, got.drop);
          check_field("read_char", want.rchar, got.rchar);
        end
      end
      // word entering the block
      if (in_valid_i && !in_stall_o) begin
        status_due.push_back(catalog_apply(dir_word_t'({command_i, dir_byte_i,
                                                        entry_index_i, char_index_i})));
        accepted_words++;
      end
      in_taken <= in_valid_i && !in_stall_o;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------

  initial begin
    logic all_bad;
    int   n;

    // directed: empty catalog, field extremes, every command
    push_word(CMD_START, 8'h00, 6'h00, 4'h0);
    push_word(CMD_READ, 8'hFF, 6'h00, 4'h0);        // empty catalog reads zero
    push_word(CMD_READ, 8'h00, 6'h3F, 4'hF);        // both indexes out of range
    push_word(CMD_END_TRACK, 8'hFF, 6'h3F, 4'hF);   // no names, scan stays open
    for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++) begin
      push_word(3'(c), 8'($urandom), 6'($urandom), 4'($urandom));
    end
    push_word(CMD_BYTE, 8'hFF, 6'h3F, 4'hF);
    push_word(CMD_BYTE, 8'h00, 6'h00, 4'h0);
    push_word(CMD_BYTE, 8'h80, 6'h2A, 4'h5);
    push_word(CMD_END_SECTOR, 8'h00, 6'h15, 4'hA);  // partial entry dropped
    push_word(CMD_BYTE, 8'h7F, 6'h00, 4'hF);
    push_word(CMD_BYTE, 8'h01, 6'h3F, 4'h0);
    push_word(CMD_END_TRACK, 8'h00, 6'h00, 4'h0);   // partial dropped, still open
    push_word(CMD_READ, 8'h00, 6'h01, 4'hA);
    push_word(CMD_START, 8'hFF, 6'h3F, 4'hF);
    push_word(CMD_END_SECTOR, 8'h00, 6'h00, 4'h0);

    // short scans: a few sectors each, duplicates, spoiled and cut entries
    while (scan_words.size() < SHORT_SCAN_WORDS) begin
      all_bad = ($urandom_range(6, 0) == 0);
      push_word(CMD_START, 8'($urandom), 6'($urandom), 4'($urandom));
      scan_names.delete();
      gen_distinct = 0;
      repeat ($urandom_range(3, 1)) begin
        repeat ($urandom_range(4, 1)) push_random_entry(all_bad ? 0 : 50, all_bad ? 0 : 25);
        if ($urandom_range(9, 0) != 0) begin
          push_word(CMD_END_SECTOR, 8'($urandom), 6'($urandom), 4'($urandom));
        end
      end
      // loose bytes, left for the end of track to discard
      if ($urandom_range(3, 0) == 0) repeat ($urandom_range(20, 1)) push_byte(8'($urandom));
      if ($urandom_range(4, 0) != 0) begin
        push_word(CMD_END_TRACK, 8'($urandom), 6'($urandom), 4'($urandom));
        repeat ($urandom_range(8, 0)) push_byte(8'($urandom));
        repeat ($urandom_range(6, 1)) push_read();
      end
    end

    // one scan that runs the catalog past full
    push_word(CMD_START, 8'($urandom), 6'($urandom), 4'($urandom));
    scan_names.delete();
    gen_distinct = 0;
    n = 0;
    while (gen_distinct < FILL_TARGET) begin
      push_random_entry(88, 6);
      n++;
      if (n % 4 == 0) push_word(CMD_END_SECTOR, 8'($urandom), 6'($urandom), 4'($urandom));
    end
    repeat (12) push_read();
    push_word(CMD_END_TRACK, 8'($urandom), 6'($urandom), 4'($urandom));
    repeat (4) push_byte(8'($urandom));
    repeat (4) push_read();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // all words taken, all status words back, then let the block settle
    while (scan_words.size() != 0 || in_valid_i) @(posedge clk_i);
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d words: %0d names stored, %0d dropped on a full catalog,",
             accepted_words, names_added, names_dropped);
    $display("%0d scans closed by end of track, %0d stored characters read back",
             scans_closed, chars_read);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("timeout with %0d status words still due", status_due.size());
    $display("simulation failed");
    $finish;
  end

endmodule
